>>> hw/rtl/sgxy_pkg.sv
// sgxy_pkg: shared widths, payload types and register codes for the separable
// x/y convolution block. No dependencies; every other file imports it.
package sgxy_pkg;

    localparam int PIX_W  = 16;   // input pixel, signed
    localparam int OP_W   = 17;   // pixel pair sum, signed
    localparam int COEF_W = 16;   // coefficient, unsigned Q0.16
    localparam int PROD_W = 34;   // OP_W x (COEF_W+1) signed product
    localparam int SUM_W  = 36;   // result sum, signed Q.16
    localparam int NCOEF  = 5;    // coefficients for distances 0..4

    localparam int COLS_W = 11;
    localparam int ROWS_W = 16;
    localparam int KW_W   = 3;
    localparam int CFG_W  = 16;
    localparam int CCOL_W = 10;
    localparam int CROW_W = 16;

    // result tdata: x_sum, y_sum, center_col, center_row, zero pad to bytes
    localparam int RES_W  = 2 * SUM_W + CCOL_W + CROW_W;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - RES_W;

    localparam logic [COLS_W-1:0] COLS_RST = 11'd1024;
    localparam logic [ROWS_W-1:0] ROWS_RST = 16'd1024;
    localparam logic [KW_W-1:0]   KW_RST   = 3'd5;

    typedef logic signed [PIX_W-1:0]  t_pix;
    typedef logic signed [OP_W-1:0]   t_op;
    typedef logic        [COEF_W-1:0] t_coef;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef enum logic [2:0] {
        CFG_IMAGE_COLS   = 3'd0,
        CFG_IMAGE_ROWS   = 3'd1,
        CFG_KERNEL_WIDTH = 3'd2,
        CFG_COEF_CENTER  = 3'd3,
        CFG_COEF_ONE     = 3'd4,
        CFG_COEF_TWO     = 3'd5,
        CFG_COEF_THREE   = 3'd6,
        CFG_COEF_FOUR    = 3'd7
    } t_cfg_idx;

endpackage

>>> hw/rtl/sgxy_lstore.sv
// sgxy_lstore: line store, one single-port bank per row slot, registered reads.
// Depends on sgxy_pkg (pixel type).
module sgxy_lstore #(
    parameter int DEPTH = 1024,
    parameter int S     = 9,
    parameter int AW    = $clog2(DEPTH),
    parameter int SW    = (S > 1) ? $clog2(S) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [SW-1:0]    i_wr_slot,
    input  logic [AW-1:0]    i_addr,
    input  sgxy_pkg::t_pix   i_wr_data,
    input  logic             i_rd_en,
    output sgxy_pkg::t_pix   o_rd_data [S]
);
    import sgxy_pkg::*;

    for (genvar b = 0; b < S; b++) begin : g_bank
        t_pix r_mem [DEPTH];
        t_pix r_rd;

        // read returns the old word when the same bank is written in this cycle
        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_slot == SW'(b))) begin
                r_mem[i_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

>>> hw/rtl/sgxy_cell.sv
// sgxy_cell: one column of the window chain; holds every row slot of one image
// column and passes it on to the next cell. Depends on sgxy_pkg.
module sgxy_cell #(
    parameter int S  = 9,
    parameter int SW = (S > 1) ? $clog2(S) : 1
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  sgxy_pkg::t_pix   i_col [S],
    input  logic [SW-1:0]    i_xslot,
    output sgxy_pkg::t_pix   o_col [S],
    output sgxy_pkg::t_pix   o_xpix
);
    import sgxy_pkg::*;

    t_pix r_col [S];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col  = r_col;
    // pixel of the horizontal-sum row in this column
    assign o_xpix = r_col[i_xslot];

endmodule

>>> hw/rtl/sgxy_tapsum.sv
// sgxy_tapsum: tap multiplies and adder tree for one direction, three stages.
// Depends on sgxy_pkg (operand, coefficient and sum types).
module sgxy_tapsum #(
    parameter int NTAP = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  sgxy_pkg::t_op     i_op   [NTAP],
    input  sgxy_pkg::t_coef   i_coef [NTAP],
    output logic              o_vld,
    output sgxy_pkg::t_sum    o_sum
);
    import sgxy_pkg::*;

    localparam int NP = (NTAP + 1) / 2;

    logic signed [PROD_W-1:0] r_prod [NTAP];
    t_sum                     r_part [NP];
    t_sum                     n_part [NP];
    t_sum                     r_sum;
    t_sum                     n_sum;
    logic                     r_vp;
    logic                     r_vq;
    logic                     r_vs;

    always_comb begin
        for (int j = 0; j < NP; j++) begin
            if (2 * j + 1 < NTAP) begin
                n_part[j] = SUM_W'(r_prod[2 * j]) + SUM_W'(r_prod[2 * j + 1]);
            end else begin
                n_part[j] = SUM_W'(r_prod[2 * j]);
            end
        end
        n_sum = '0;
        for (int j = 0; j < NP; j++) begin
            n_sum = n_sum + r_part[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vq <= 1'b0;
            r_vs <= 1'b0;
        end else if (i_en) begin
            r_vp <= i_vld;
            r_vq <= r_vp;
            r_vs <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NTAP; k++) begin
                r_prod[k] <= i_op[k] * $signed({1'b0, i_coef[k]});
            end
            r_part <= n_part;
            r_sum  <= n_sum;
        end
    end

    assign o_vld = r_vs;
    assign o_sum = r_sum;

endmodule

>>> hw/rtl/separable_gauss_xy_convolution.sv
// separable_gauss_xy_convolution: top level of the symmetric separable x/y filter.
// Depends on sgxy_pkg, sgxy_lstore, sgxy_cell and sgxy_tapsum.
//
// Channel   Dir  Handshake                   Payload (low bit first)
// s_axis    in   i_s_axis_tvalid/o_..tready  tdata: pixel[15:0]; tuser: frame_start
// m_axis    out  o_m_axis_tvalid/i_..tready  tdata: x_sum, y_sum, center_col,
//                                            center_row, zero pad
// cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index (register), i_cfg_data
//
// One pixel per clock while the skid register is not full. After the transfer of the
// pixel that completes its window, a result passes the chain, two select stages,
// multiply and two adder stages to the output (the store is read at the transfer edge).
// The line store is written and all its banks are read in the transfer cycle, so
// its single port per bank sets the rate.
// Reset clears counters and handshake state and sets the config registers to their reset
// values; the line store is not cleared and holds garbage until a row is written.
// A stalled output takes one more result in the skid register, then s_axis stalls.
module separable_gauss_xy_convolution #(
    parameter int MAX_TAPS = 5,
    parameter int MAX_COLS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [sgxy_pkg::PIX_W-1:0]    i_s_axis_tdata,   // [15:0] pixel
    input  logic                          i_s_axis_tuser,   // [0] frame_start
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [35:0] x_sum, [71:36] y_sum, [81:72] center_col, [97:82] center_row
    output logic [sgxy_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  sgxy_pkg::t_cfg_idx            i_cfg_index,
    input  logic [sgxy_pkg::CFG_W-1:0]    i_cfg_data
);
    import sgxy_pkg::*;

    localparam int S    = 2 * MAX_TAPS - 1;                  // row slots = chain cells
    localparam int SW   = (S > 1) ? $clog2(S) : 1;
    localparam int CW   = $clog2(MAX_COLS);
    localparam int HW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NTAP = (MAX_TAPS < NCOEF) ? MAX_TAPS : NCOEF;
    localparam int XW   = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

    // ------------------------------------------------------------------
    // slot arithmetic modulo S on narrow values
    function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] s,
                                                input logic [SW-1:0] d);
        return (s >= d) ? (s - d) : (s + SW'(S) - d);
    endfunction

    function automatic logic [SW-1:0] slot_fwd(input logic [SW-1:0] s,
                                               input logic [SW-1:0] d);
        logic [SW:0] t;
        t = {1'b0, s} + {1'b0, d};
        return (t >= (SW + 1)'(S)) ? SW'(t - (SW + 1)'(S)) : SW'(t);
    endfunction

    // ------------------------------------------------------------------
    // config registers
    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic [KW_W-1:0]   r_kw;
    t_coef             r_coef [NCOEF];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
            r_kw   <= KW_RST;
            for (int k = 0; k < NCOEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_COLS:   r_cols    <= i_cfg_data[COLS_W-1:0];
                CFG_IMAGE_ROWS:   r_rows    <= i_cfg_data[ROWS_W-1:0];
                CFG_KERNEL_WIDTH: r_kw      <= i_cfg_data[KW_W-1:0];
                CFG_COEF_CENTER:  r_coef[0] <= i_cfg_data;
                CFG_COEF_ONE:     r_coef[1] <= i_cfg_data;
                CFG_COEF_TWO:     r_coef[2] <= i_cfg_data;
                CFG_COEF_THREE:   r_coef[3] <= i_cfg_data;
                CFG_COEF_FOUR:    r_coef[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: whole pipe moves unless the skid register is full
    logic en;
    logic acc;
    logic r_out_vld;
    logic r_skid_vld;

    assign en              = !r_skid_vld;
    assign o_s_axis_tready = en;
    assign acc             = i_s_axis_tvalid && en;

    // ------------------------------------------------------------------
    // stage 0: position counters, window test, store access
    logic [CW-1:0]     r_col;
    logic [ROWS_W-1:0] r_row;
    logic [SW-1:0]     r_slot;      // r_row mod S

    logic [CW-1:0]     c_cur;
    logic [ROWS_W-1:0] row_cur;
    logic [SW-1:0]     s_cur;
    logic [XW-1:0]     cols_eff;
    logic [ROWS_W:0]   rows_eff;
    logic [3:0]        kw_eff;
    logic [HW-1:0]     h_cur;
    logic [HW:0]       h2;
    logic              win;
    logic [CW-1:0]     n_col;
    logic [ROWS_W-1:0] n_row;
    logic [SW-1:0]     n_slot;

    always_comb begin
        c_cur   = i_s_axis_tuser ? '0 : r_col;
        row_cur = i_s_axis_tuser ? '0 : r_row;
        s_cur   = i_s_axis_tuser ? '0 : r_slot;

        cols_eff = XW'(r_cols);
        if (cols_eff == '0) begin
            cols_eff = XW'(1);
        end else if (cols_eff > XW'(MAX_COLS)) begin
            cols_eff = XW'(MAX_COLS);
        end
        rows_eff = (r_rows == '0) ? (ROWS_W + 1)'(1) : {1'b0, r_rows};
        kw_eff = {1'b0, r_kw};
        if (kw_eff == '0) begin
            kw_eff = 4'd1;
        end else if (kw_eff > 4'(MAX_TAPS)) begin
            kw_eff = 4'(MAX_TAPS);
        end
        h_cur = HW'(kw_eff - 4'd1);
        h2    = {h_cur, 1'b0};

        win = (XW'(c_cur) < cols_eff) && ({1'b0, row_cur} < rows_eff)
            && (c_cur >= CW'(h2)) && (row_cur >= ROWS_W'(h2));

        // counters after this pixel
        if (XW'(c_cur) + XW'(1) >= cols_eff) begin
            n_col = '0;
            if ({1'b0, row_cur} + (ROWS_W + 1)'(1) >= rows_eff) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = row_cur + ROWS_W'(1);
                n_slot = (s_cur == SW'(S - 1)) ? '0 : s_cur + SW'(1);
            end
        end else begin
            n_col  = c_cur + CW'(1);
            n_row  = row_cur;
            n_slot = s_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    t_pix rd_data [S];

    sgxy_lstore #(
        .DEPTH (MAX_COLS),
        .S     (S)
    ) u_lstore (
        .i_clk     (i_clk),
        .i_wr_en   (acc),
        .i_wr_slot (s_cur),
        .i_addr    (c_cur),
        .i_wr_data ($signed(i_s_axis_tdata)),
        .i_rd_en   (acc),
        .o_rd_data (rd_data)
    );

    // stage 1: store read data arrives, pixel waits for write-through
    logic              r_s1_vld;
    logic              r_s1_res;
    t_pix              r_s1_pix;
    logic [SW-1:0]     r_s1_slot;
    logic [SW-1:0]     r_s1_slotc;
    logic [HW-1:0]     r_s1_h;
    logic [CW-1:0]     r_s1_cc;
    logic [ROWS_W-1:0] r_s1_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_res   <= win;
            r_s1_pix   <= $signed(i_s_axis_tdata);
            r_s1_slot  <= s_cur;
            r_s1_slotc <= slot_back(s_cur, SW'(h_cur));  // slot of the center row
            r_s1_h     <= h_cur;
            r_s1_cc    <= c_cur - CW'(h_cur);
            r_s1_cr    <= row_cur - ROWS_W'(h_cur);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: column chain; cell i holds image column (c - i) of every slot
    t_pix          chain_in [S][S];
    t_pix          cellcol  [S][S];
    t_pix          xpix     [S];
    logic          shift;
    logic          r_s2_res;
    logic [SW-1:0] r_s2_slotc;
    logic [HW-1:0] r_s2_h;
    logic [CW-1:0] r_s2_cc;
    logic [ROWS_W-1:0] r_s2_cr;

    assign shift = en && r_s1_vld;

    always_comb begin
        for (int s = 0; s < S; s++) begin
            // the current row's slot takes the new pixel, not the stale read
            chain_in[0][s] = (SW'(s) == r_s1_slot) ? r_s1_pix : rd_data[s];
        end
        for (int i = 1; i < S; i++) begin
            chain_in[i] = cellcol[i - 1];
        end
    end

    for (genvar gi = 0; gi < S; gi++) begin : g_chain
        sgxy_cell #(
            .S (S)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_col   (chain_in[gi]),
            .i_xslot (r_s2_slotc),
            .o_col   (cellcol[gi]),
            .o_xpix  (xpix[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_res <= 1'b0;
        end else if (en) begin
            r_s2_res <= r_s1_vld && r_s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_slotc <= r_s1_slotc;
            r_s2_h     <= r_s1_h;
            r_s2_cc    <= r_s1_cc;
            r_s2_cr    <= r_s1_cr;
        end
    end

    // stage 3: capture the center row across cells and the center column
    t_pix              r_s3_xrow [S];
    t_pix              r_s3_ycol [S];
    logic              r_s3_res;
    logic [SW-1:0]     r_s3_slotc;
    logic [HW-1:0]     r_s3_h;
    logic [CW-1:0]     r_s3_cc;
    logic [ROWS_W-1:0] r_s3_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_res <= 1'b0;
        end else if (en) begin
            r_s3_res <= r_s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_xrow  <= xpix;
            r_s3_ycol  <= cellcol[SW'(r_s2_h)];
            r_s3_slotc <= r_s2_slotc;
            r_s3_h     <= r_s2_h;
            r_s3_cc    <= r_s2_cc;
            r_s3_cr    <= r_s2_cr;
        end
    end

    // stage 4: symmetric pair sums; taps beyond the half width are zeroed
    t_op               n_opx [NTAP];
    t_op               n_opy [NTAP];
    t_op               r_s4_opx [NTAP];
    t_op               r_s4_opy [NTAP];
    logic              r_s4_res;
    logic [CW-1:0]     r_s4_cc;
    logic [ROWS_W-1:0] r_s4_cr;

    always_comb begin
        t_pix xa;
        t_pix xb;
        t_pix ya;
        t_pix yb;
        logic [SW-1:0] hs;
        hs = SW'(r_s3_h);
        xb = '0;
        ya = '0;
        yb = '0;
        xa = r_s3_xrow[hs];
        n_opx[0] = {xa[PIX_W-1], xa};
        n_opy[0] = {xa[PIX_W-1], xa};
        for (int k = 1; k < NTAP; k++) begin
            if (SW'(k) <= hs) begin
                xa = r_s3_xrow[hs - SW'(k)];
                xb = r_s3_xrow[hs + SW'(k)];
                ya = r_s3_ycol[slot_back(r_s3_slotc, SW'(k))];
                yb = r_s3_ycol[slot_fwd(r_s3_slotc, SW'(k))];
                n_opx[k] = {xa[PIX_W-1], xa} + {xb[PIX_W-1], xb};
                n_opy[k] = {ya[PIX_W-1], ya} + {yb[PIX_W-1], yb};
            end else begin
                n_opx[k] = '0;
                n_opy[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_res <= 1'b0;
        end else if (en) begin
            r_s4_res <= r_s3_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_opx <= n_opx;
            r_s4_opy <= n_opy;
            r_s4_cc  <= r_s3_cc;
            r_s4_cr  <= r_s3_cr;
        end
    end

    // stages 5..7: multiply and add, center position rides alongside
    t_coef tap_coef [NTAP];
    logic  x_vld;
    logic  y_vld;
    t_sum  x_sum;
    t_sum  y_sum;

    for (genvar gk = 0; gk < NTAP; gk++) begin : g_coef
        assign tap_coef[gk] = r_coef[gk];
    end

    sgxy_tapsum #(
        .NTAP (NTAP)
    ) u_xsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s4_res),
        .i_op    (r_s4_opx),
        .i_coef  (tap_coef),
        .o_vld   (x_vld),
        .o_sum   (x_sum)
    );

    sgxy_tapsum #(
        .NTAP (NTAP)
    ) u_ysum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s4_res),
        .i_op    (r_s4_opy),
        .i_coef  (tap_coef),
        .o_vld   (y_vld),
        .o_sum   (y_sum)
    );

    logic [CW-1:0]     r_s5_cc;
    logic [CW-1:0]     r_s6_cc;
    logic [CW-1:0]     r_s7_cc;
    logic [ROWS_W-1:0] r_s5_cr;
    logic [ROWS_W-1:0] r_s6_cr;
    logic [ROWS_W-1:0] r_s7_cr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_cc <= r_s4_cc;
            r_s6_cc <= r_s5_cc;
            r_s7_cc <= r_s6_cc;
            r_s5_cr <= r_s4_cr;
            r_s6_cr <= r_s5_cr;
            r_s7_cr <= r_s6_cr;
        end
    end

    // ------------------------------------------------------------------
    // output register plus one-deep skid
    logic [OUT_W-1:0] res_data;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] r_skid_data;

    assign res_data = {{PAD_W{1'b0}}, CROW_W'(r_s7_cr), CCOL_W'(r_s7_cc), y_sum, x_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= x_vld;
            end
        end else if (x_vld && en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_axis_tready) begin
            r_out_data <= r_skid_vld ? r_skid_data : res_data;
        end else if (x_vld && en) begin
            r_skid_data <= res_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    a_sums_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_vld == y_vld)
        else $error("x and y sum pipelines out of step");

    a_slot_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == '0) |-> (r_slot == '0))
        else $error("row slot not aligned with row counter");

endmodule
